[rtl/kmst_pkg.sv]
// Package for the Kruskal spanning-forest block: field widths, limits and
// parameter defaults. No dependencies.
`default_nettype none
package kmst_pkg;
  localparam int unsigned NODE_W       = 6;
  localparam int unsigned WEIGHT_IN_W  = 16;
  localparam int unsigned RESULT_LIMIT = 63;
  localparam int unsigned NODES_DEF    = 64;
  localparam int unsigned EDGES_DEF    = 128;
  localparam int unsigned WBITS_DEF    = 16;
endpackage
`default_nettype wire

[rtl/kmst_edge_store.sv]
// Edge store: one write port, one registered read port.
// Depends on kmst_pkg.
`default_nettype none
module kmst_edge_store #(
  parameter int unsigned EDGES       = 128,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [$clog2(EDGES)-1:0]      waddr_i,
  input  wire logic [kmst_pkg::NODE_W-1:0]   wfirst_i,
  input  wire logic [kmst_pkg::NODE_W-1:0]   wsecond_i,
  input  wire logic [WEIGHT_BITS-1:0]        wweight_i,
  input  wire logic [$clog2(EDGES)-1:0]      raddr_i,
  output logic      [kmst_pkg::NODE_W-1:0]   rfirst_o,
  output logic      [kmst_pkg::NODE_W-1:0]   rsecond_o,
  output logic      [WEIGHT_BITS-1:0]        rweight_o
);
  import kmst_pkg::*;

  localparam int unsigned EW = 2 * NODE_W + WEIGHT_BITS;

  logic [EW-1:0] mem [EDGES];
  logic [EW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wfirst_i, wsecond_i, wweight_i};
    end
    rd_q <= mem[raddr_i];
  end

  assign rfirst_o  = rd_q[EW-1 -: NODE_W];
  assign rsecond_o = rd_q[WEIGHT_BITS +: NODE_W];
  assign rweight_o = rd_q[WEIGHT_BITS-1:0];
endmodule
`default_nettype wire

[rtl/kmst_parent_mem.sv]
// Union-find parent table: memory with per-entry valid bits so that an
// unwritten entry reads as its own index. Depends on kmst_pkg.
`default_nettype none
module kmst_parent_mem #(
  parameter int unsigned NODES = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      clear_i,
  input  wire logic                      we_i,
  input  wire logic [$clog2(NODES)-1:0]  waddr_i,
  input  wire logic [$clog2(NODES)-1:0]  wdata_i,
  input  wire logic [$clog2(NODES)-1:0]  raddr_i,
  output logic      [$clog2(NODES)-1:0]  rdata_o
);
  import kmst_pkg::*;

  localparam int unsigned NW = $clog2(NODES);

  logic [NW-1:0]    mem [NODES];
  logic [NODES-1:0] valid_q;
  logic [NW-1:0]    rd_q;
  logic [NW-1:0]    raddr_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q    <= mem[raddr_i];
    raddr_q <= raddr_i;
  end

  assign rdata_o = rvalid_q ? rd_q : raddr_q;
endmodule
`default_nettype wire

[rtl/kruskal_mst_union_find.sv]
// Kruskal spanning-forest block: sequencer, edge selection and union-find.
// Depends on kmst_pkg, kmst_edge_store, kmst_parent_mem.
//
// Usage: edges enter on the input channel (valid/stall), one per cycle while
// loading. Each is stored; once EDGES are held, further edges are dropped and
// the overflow flag of the run is set. The edge with last_edge set closes
// the set and starts the run; in_stall_o stays high until the run is over.
// The run selects edges in ascending weight (ties in load order) by a full
// scan of the store per edge (states SCAN_RD and SCAN_CMP per stored edge),
// followed by the union-find walks (FIND_RD and FIND_CHK per parent step).
// Each spanning edge is a result on the output channel; the final one
// carries last_result, or a single empty result is given when no edge
// joins two trees. Results are held in an output register: while the
// receiver stalls the sequencer waits before the next result.
// After reset the store is empty and the parent table is identity; no
// clearing pass is needed.
`default_nettype none
module kruskal_mst_union_find #(
  parameter int unsigned NODES       = kmst_pkg::NODES_DEF,
  parameter int unsigned EDGES       = kmst_pkg::EDGES_DEF,
  parameter int unsigned WEIGHT_BITS = kmst_pkg::WBITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [kmst_pkg::NODE_W-1:0]        node_first_i,
  input  wire logic [kmst_pkg::NODE_W-1:0]        node_second_i,
  input  wire logic [kmst_pkg::WEIGHT_IN_W-1:0]   edge_weight_i,
  input  wire logic                               last_edge_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [kmst_pkg::NODE_W-1:0]        tree_first_o,
  output logic      [kmst_pkg::NODE_W-1:0]        tree_second_o,
  output logic      [kmst_pkg::WEIGHT_IN_W-1:0]   tree_weight_o,
  output logic                                    edge_found_o,
  output logic                                    last_result_o,
  output logic                                    overflow_o
);
  import kmst_pkg::*;

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned IW = $clog2(EDGES);
  localparam int unsigned CW = $clog2(EDGES + 1);
  localparam int unsigned RW = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [3:0] {
    ST_LOAD, ST_SCAN_RD, ST_SCAN_CMP, ST_FIND_RD, ST_FIND_CHK,
    ST_COMP_RD, ST_COMP_CHK, ST_LINK, ST_FINISH
  } state_e;

  // reduce a node index modulo NODES by restoring subtraction
  function automatic logic [NODE_W-1:0] node_mod(input logic [NODE_W-1:0] v);
    logic [31:0] t;
    logic [31:0] sub;
    t = 32'(v);
    for (int k = NODE_W - 1; k >= 0; k--) begin
      sub = 32'(NODES) << k;
      if (t >= sub) t = t - sub;
    end
    return t[NODE_W-1:0];
  endfunction

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   ovf_q, ovf_d;
  logic [CW-1:0]          j_q, j_d;
  logic                   best_v_q, best_v_d;
  logic [IW-1:0]          best_i_q, best_i_d;
  logic [NODE_W-1:0]      best_f_q, best_f_d, best_s_q, best_s_d;
  logic [WEIGHT_BITS-1:0] best_w_q, best_w_d;
  logic                   prev_v_q, prev_v_d;
  logic [IW-1:0]          prev_i_q, prev_i_d;
  logic [WEIGHT_BITS-1:0] prev_w_q, prev_w_d;
  logic                   which_q, which_d;
  logic [NW-1:0]          r_q, r_d, cur_q, cur_d, ra_q, ra_d;
  logic                   pend_v_q, pend_v_d;
  logic [NODE_W-1:0]      pend_f_q, pend_f_d, pend_s_q, pend_s_d;
  logic [WEIGHT_BITS-1:0] pend_w_q, pend_w_d;
  logic [RW-1:0]          rcnt_q, rcnt_d;
  logic                   ov_q, ov_d;
  logic [NODE_W-1:0]      of_q, of_d, os_q, os_d;
  logic [WEIGHT_IN_W-1:0] ow_q, ow_d;
  logic                   ofound_q, ofound_d, olast_q, olast_d, oovf_q, oovf_d;

  logic                   st_we;
  logic [IW-1:0]          st_raddr;
  logic [NODE_W-1:0]      st_f, st_s;
  logic [WEIGHT_BITS-1:0] st_w;
  logic                   pm_clear, pm_we;
  logic [NW-1:0]          pm_waddr, pm_wdata, pm_raddr, pm_rdata;
  logic                   in_acc, out_busy, cand;

  assign in_acc   = in_valid_i && (state_q == ST_LOAD);
  assign out_busy = ov_q && out_stall_i;
  assign st_we    = in_acc && (count_q < CW'(EDGES));

  kmst_edge_store #(.EDGES(EDGES), .WEIGHT_BITS(WEIGHT_BITS)) u_store (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (count_q[IW-1:0]),
    .wfirst_i  (node_mod(node_first_i)),
    .wsecond_i (node_mod(node_second_i)),
    .wweight_i (WEIGHT_BITS'(edge_weight_i)),
    .raddr_i   (st_raddr),
    .rfirst_o  (st_f),
    .rsecond_o (st_s),
    .rweight_o (st_w)
  );

  kmst_parent_mem #(.NODES(NODES)) u_parent (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (pm_clear),
    .we_i    (pm_we),
    .waddr_i (pm_waddr),
    .wdata_i (pm_wdata),
    .raddr_i (pm_raddr),
    .rdata_o (pm_rdata)
  );

  assign st_raddr = j_q[IW-1:0];
  assign pm_clear = in_acc && last_edge_i;
  assign pm_raddr = (state_q == ST_COMP_RD) ? cur_q : r_q;
  assign pm_we    = ((state_q == ST_COMP_CHK) && (pm_rdata != r_q)) || (state_q == ST_LINK);
  assign pm_waddr = (state_q == ST_LINK) ? ra_q : cur_q;
  assign pm_wdata = r_q;

  // edge comes after the previous pick in (weight, load order) and beats best
  assign cand = (!prev_v_q || (st_w > prev_w_q) ||
                 ((st_w == prev_w_q) && (j_q[IW-1:0] > prev_i_q))) &&
                (!best_v_q || (st_w < best_w_q));

  always_comb begin
    state_d  = state_q;  count_d  = count_q;  ovf_d    = ovf_q;
    j_d      = j_q;      best_v_d = best_v_q; best_i_d = best_i_q;
    best_f_d = best_f_q; best_s_d = best_s_q; best_w_d = best_w_q;
    prev_v_d = prev_v_q; prev_i_d = prev_i_q; prev_w_d = prev_w_q;
    which_d  = which_q;  r_d      = r_q;      cur_d    = cur_q;
    ra_d     = ra_q;     pend_v_d = pend_v_q; pend_f_d = pend_f_q;
    pend_s_d = pend_s_q; pend_w_d = pend_w_q; rcnt_d   = rcnt_q;
    ov_d     = ov_q && out_stall_i;
    of_d     = of_q;     os_d     = os_q;     ow_d     = ow_q;
    ofound_d = ofound_q; olast_d  = olast_q;  oovf_d   = oovf_q;

    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (st_we) count_d = count_q + 1'b1;
          else       ovf_d   = 1'b1;
          if (last_edge_i) begin
            j_d = '0; best_v_d = 1'b0; prev_v_d = 1'b0;
            pend_v_d = 1'b0; rcnt_d = '0;
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        if (j_q == count_q) begin
          if (!best_v_q) begin
            state_d = ST_FINISH;
          end else begin
            prev_v_d = 1'b1; prev_i_d = best_i_q; prev_w_d = best_w_q;
            which_d = 1'b0; r_d = NW'(best_f_q);
            state_d = ST_FIND_RD;
          end
        end else begin
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (cand) begin
          best_v_d = 1'b1; best_i_d = j_q[IW-1:0];
          best_f_d = st_f; best_s_d = st_s; best_w_d = st_w;
        end
        j_d = j_q + 1'b1;
        state_d = ST_SCAN_RD;
      end
      ST_FIND_RD: state_d = ST_FIND_CHK;
      ST_FIND_CHK: begin
        if (pm_rdata == r_q) begin
          cur_d = which_q ? NW'(best_s_q) : NW'(best_f_q);
          state_d = ST_COMP_RD;
        end else begin
          r_d = pm_rdata;
          state_d = ST_FIND_RD;
        end
      end
      ST_COMP_RD: state_d = ST_COMP_CHK;
      ST_COMP_CHK: begin
        if (pm_rdata == r_q) begin
          if (!which_q) begin
            ra_d = r_q; which_d = 1'b1; r_d = NW'(best_s_q);
            state_d = ST_FIND_RD;
          end else if (ra_q != r_q) begin
            state_d = ST_LINK;
          end else begin
            j_d = '0; best_v_d = 1'b0;
            state_d = ST_SCAN_RD;
          end
        end else begin
          // point this node straight at the root, then follow the old link
          cur_d = pm_rdata;
          state_d = ST_COMP_RD;
        end
      end
      ST_LINK: begin
        if (rcnt_q < RW'(RESULT_LIMIT)) begin
          if (!(pend_v_q && out_busy)) begin
            if (pend_v_q) begin
              ov_d = 1'b1; of_d = pend_f_q; os_d = pend_s_q;
              ow_d = WEIGHT_IN_W'(pend_w_q);
              ofound_d = 1'b1; olast_d = 1'b0; oovf_d = ovf_q;
            end
            pend_v_d = 1'b1; pend_f_d = best_f_q; pend_s_d = best_s_q;
            pend_w_d = best_w_q; rcnt_d = rcnt_q + 1'b1;
            j_d = '0; best_v_d = 1'b0;
            state_d = ST_SCAN_RD;
          end
        end else begin
          j_d = '0; best_v_d = 1'b0;
          state_d = ST_SCAN_RD;
        end
      end
      ST_FINISH: begin
        if (!out_busy) begin
          ov_d = 1'b1; olast_d = 1'b1; oovf_d = ovf_q;
          ofound_d = pend_v_q;
          of_d = pend_v_q ? pend_f_q : '0;
          os_d = pend_v_q ? pend_s_q : '0;
          ow_d = pend_v_q ? WEIGHT_IN_W'(pend_w_q) : '0;
          count_d = '0; ovf_d = 1'b0;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      j_q      <= '0;
      best_v_q <= 1'b0;
      prev_v_q <= 1'b0;
      which_q  <= 1'b0;
      pend_v_q <= 1'b0;
      rcnt_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      j_q      <= j_d;
      best_v_q <= best_v_d;
      prev_v_q <= prev_v_d;
      which_q  <= which_d;
      pend_v_q <= pend_v_d;
      rcnt_q   <= rcnt_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_i_q <= best_i_d; best_f_q <= best_f_d; best_s_q <= best_s_d;
    best_w_q <= best_w_d; prev_i_q <= prev_i_d; prev_w_q <= prev_w_d;
    r_q      <= r_d;      cur_q    <= cur_d;    ra_q     <= ra_d;
    pend_f_q <= pend_f_d; pend_s_q <= pend_s_d; pend_w_q <= pend_w_d;
    of_q     <= of_d;     os_q     <= os_d;     ow_q     <= ow_d;
    ofound_q <= ofound_d; olast_q  <= olast_d;  oovf_q   <= oovf_d;
  end

  assign in_stall_o    = (state_q != ST_LOAD);
  assign out_valid_o   = ov_q;
  assign tree_first_o  = of_q;
  assign tree_second_o = os_q;
  assign tree_weight_o = ow_q;
  assign edge_found_o  = ofound_q;
  assign last_result_o = olast_q;
  assign overflow_o    = oovf_q;
endmodule
`default_nettype wire
